// ===== rtl/utf8_aware_byte_escaper_unit_macros.svh =====
// Assertion macros shared by the byte escaper modules.
`ifndef UTF8_AWARE_BYTE_ESCAPER_UNIT_MACROS_SVH
`define UTF8_AWARE_BYTE_ESCAPER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define UBE_ASSERT(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed in byte escaper");
// Condition must never be true at a clock edge outside reset.
`define UBE_NEVER(label, clock, rst_n, cond) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen in byte escaper");
`else
`define UBE_ASSERT(label, clock, rst_n, prop)
`define UBE_NEVER(label, clock, rst_n, cond)
`endif

`endif

// ===== rtl/ube_pkg.sv =====
// Types, constants and helper functions of the byte escaper.
package ube_pkg;

	localparam logic [7:0] CHR_BSLASH = 8'h5c;
	localparam logic [7:0] CHR_X      = 8'h78;
	localparam logic [7:0] CONT_MASK  = 8'hc0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD_E0    = 8'he0;
	localparam logic [7:0] LEAD_ED    = 8'hed;
	localparam logic [7:0] LEAD_F0    = 8'hf0;
	localparam logic [7:0] LEAD_F4    = 8'hf4;
	localparam logic [7:0] LIM_A0     = 8'ha0;
	localparam logic [7:0] LIM_90     = 8'h90;
	localparam logic [1:0] CHR_LAST   = 2'd3;

	// Up to four tokens per input byte; an escaped token expands to four characters.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [3:0]      esc;
		logic [2:0]      count;
		logic            last;
	} tok_list_t;

	function automatic logic [2:0] lead_width(input logic [7:0] c);
		logic [2:0] w;
		w = 3'd0;
		if (c inside {[8'hc2:8'hdf]}) w = 3'd2;
		else if (c inside {[8'he0:8'hef]}) w = 3'd3;
		else if (c inside {[8'hf0:8'hf4]}) w = 3'd4;
		return w;
	endfunction

	function automatic logic is_plain(input logic [7:0] c);
		return c inside {[8'h20:8'h7e], 8'h0a, 8'h0d, 8'h09};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) c = 8'h30 + {4'd0, n};
		else c = 8'h57 + {4'd0, n};
		return c;
	endfunction

endpackage

// ===== rtl/ube_front.sv =====
// Sequence tracker: decodes one byte per cycle unless stalled into a token list and holds it in a skid stage.
`include "utf8_aware_byte_escaper_unit_macros.svh"

module ube_front import ube_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tlast,
	output tok_list_t  tok_s1,
	output logic       vld_s1,
	input  logic       take
);

	logic [2:0][7:0] held_q;
	logic [1:0]      cnt_q;
	logic [2:0]      ew_q;

	logic [2:0][7:0] held_d;
	logic [1:0]      cnt_d;
	logic [2:0]      ew_d;
	tok_list_t       tok_d;
	logic            cont;
	logic            do_fresh;
	logic [2:0]      w;
	logic            accept;
	logic [7:0]      b;

	assign b = s_axis_tdata;

	always_comb begin
		cont = ((b & CONT_MASK) == CONT_TAG);
		if (cnt_q == 2'd1) begin
			if (held_q[0] == LEAD_E0 && b < LIM_A0) cont = 1'b0;
			if (held_q[0] == LEAD_ED && b >= LIM_A0) cont = 1'b0;
			if (held_q[0] == LEAD_F0 && b < LIM_90) cont = 1'b0;
			if (held_q[0] == LEAD_F4 && b >= LIM_90) cont = 1'b0;
		end
	end

	assign w = lead_width(b);

	// Token list is built by appending at tok_d.count; at most four appends can happen.
	always_comb begin
		held_d = held_q;
		cnt_d = cnt_q;
		ew_d = ew_q;
		tok_d = '0;
		tok_d.last = s_axis_tlast;
		do_fresh = 1'b0;
		if (cnt_q == 2'd0) begin
			do_fresh = 1'b1;
		end else if (!cont) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < cnt_q && tok_d.count < 3'd4) begin
					tok_d.bytes[tok_d.count[1:0]] = held_q[k];
					tok_d.esc[tok_d.count[1:0]] = 1'b1;
					tok_d.count = tok_d.count + 3'd1;
				end
			end
			cnt_d = 2'd0;
			ew_d = 3'd0;
			do_fresh = 1'b1;
		end else if ({1'b0, cnt_q} + 3'd1 >= ew_q) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < cnt_q && tok_d.count < 3'd4) begin
					tok_d.bytes[tok_d.count[1:0]] = held_q[k];
					tok_d.count = tok_d.count + 3'd1;
				end
			end
			if (tok_d.count < 3'd4) begin
				tok_d.bytes[tok_d.count[1:0]] = b;
				tok_d.count = tok_d.count + 3'd1;
			end
			cnt_d = 2'd0;
			ew_d = 3'd0;
		end else begin
			held_d[cnt_q] = b;
			cnt_d = cnt_q + 2'd1;
		end
		if (do_fresh) begin
			if (b < CONT_TAG || w == 3'd0) begin
				if (tok_d.count < 3'd4) begin
					tok_d.bytes[tok_d.count[1:0]] = b;
					tok_d.esc[tok_d.count[1:0]] = (b < CONT_TAG) ? !is_plain(b) : 1'b1;
					tok_d.count = tok_d.count + 3'd1;
				end
			end else begin
				held_d[0] = b;
				cnt_d = 2'd1;
				ew_d = w;
			end
		end
		// A sequence still open at the end of the text is escaped byte by byte.
		if (s_axis_tlast && cnt_d != 2'd0) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < cnt_d && tok_d.count < 3'd4) begin
					tok_d.bytes[tok_d.count[1:0]] = held_d[k];
					tok_d.esc[tok_d.count[1:0]] = 1'b1;
					tok_d.count = tok_d.count + 3'd1;
				end
			end
			cnt_d = 2'd0;
			ew_d = 3'd0;
		end
	end

	assign s_axis_tready = !vld_s1 || take;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			ew_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			ew_q <= ew_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= (tok_d.count != 3'd0);
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= tok_d;
		end
	end

	`UBE_ASSERT(a_cnt_below_width, clk, arst_n, (cnt_q != 2'd0) |-> ({1'b0, cnt_q} < ew_q))
	`UBE_ASSERT(a_last_clears, clk, arst_n, (accept && s_axis_tlast) |=> (cnt_q == 2'd0))
	`UBE_ASSERT(a_s1_holds, clk, arst_n, (vld_s1 && !take) |=> (vld_s1 && $stable(tok_s1)))

endmodule

// ===== rtl/ube_emit.sv =====
// Output serializer: sends a token list one character per cycle while m_axis_tready is high, expanding escapes.
`include "utf8_aware_byte_escaper_unit_macros.svh"

module ube_emit import ube_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tok_list_t  tok_s1,
	input  logic       vld_s1,
	output logic       take,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,
	output logic       m_axis_tlast,
	output logic       m_axis_tuser
);

	tok_list_t  ser_q;
	logic       ser_vld_q;
	logic [1:0] tok_idx_q;
	logic [1:0] chr_idx_q;

	logic [7:0] cur_byte;
	logic       cur_esc;
	logic       tok_end;
	logic       item_end;
	logic       fire;

	assign cur_byte = ser_q.bytes[tok_idx_q];
	assign cur_esc = ser_q.esc[tok_idx_q];
	assign tok_end = cur_esc ? (chr_idx_q == CHR_LAST) : 1'b1;
	assign item_end = tok_end && ({1'b0, tok_idx_q} + 3'd1 == ser_q.count);

	always_comb begin
		if (!cur_esc) begin
			m_axis_tdata = cur_byte;
		end else begin
			case (chr_idx_q)
				2'd0: m_axis_tdata = CHR_BSLASH;
				2'd1: m_axis_tdata = CHR_X;
				2'd2: m_axis_tdata = hex_char(cur_byte[7:4]);
				default: m_axis_tdata = hex_char(cur_byte[3:0]);
			endcase
		end
	end

	assign m_axis_tvalid = ser_vld_q;
	assign m_axis_tlast = item_end;
	assign m_axis_tuser = item_end && ser_q.last;
	assign fire = m_axis_tvalid && m_axis_tready;
	assign take = vld_s1 && (!ser_vld_q || (fire && item_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			tok_idx_q <= 2'd0;
			chr_idx_q <= 2'd0;
		end else if (take) begin
			ser_vld_q <= 1'b1;
			tok_idx_q <= 2'd0;
			chr_idx_q <= 2'd0;
		end else if (fire) begin
			if (item_end) begin
				ser_vld_q <= 1'b0;
			end else if (tok_end) begin
				tok_idx_q <= tok_idx_q + 2'd1;
				chr_idx_q <= 2'd0;
			end else begin
				chr_idx_q <= chr_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ser_q <= tok_s1;
		end
	end

	`UBE_ASSERT(a_raw_single_chr, clk, arst_n, (ser_vld_q && !cur_esc) |-> (chr_idx_q == 2'd0))
	`UBE_ASSERT(a_idx_in_list, clk, arst_n, ser_vld_q |-> ({1'b0, tok_idx_q} < ser_q.count))
	`UBE_ASSERT(a_end_drains, clk, arst_n, (fire && item_end && !take) |=> !ser_vld_q)

endmodule

// ===== rtl/utf8_aware_byte_escaper_unit.sv =====
// Top level of the UTF-8 aware byte escaper.
// Takes one raw byte per item and renders it as text: valid UTF-8 sequences and printable
// ASCII (plus newline, carriage return and tab) pass through, every other byte becomes
// the four characters \xHH with lowercase hex digits. An input byte can produce zero to
// sixteen output characters; the output sends one character per cycle while m_axis_tready
// is high. The decoder accepts one byte per cycle as long as the output keeps up; it is
// stalled only when both the one-item skid stage after the decoder and the output
// serializer are occupied. An accepted byte passes through the skid stage and then the
// serializer register before it reaches the output. m_axis_tlast marks the last
// character produced by an input byte, m_axis_tuser the last character of the whole text.
module utf8_aware_byte_escaper_unit import ube_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_char
	output logic       m_axis_tlast,  // run_last
	output logic       m_axis_tuser   // [0] text_end
);

	tok_list_t tok_s1;
	logic      vld_s1;
	logic      take;

	ube_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.tok_s1        (tok_s1),
		.vld_s1        (vld_s1),
		.take          (take)
	);

	ube_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_s1        (tok_s1),
		.vld_s1        (vld_s1),
		.take          (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== tb/tb_utf8_aware_byte_escaper_unit.sv =====
// Self-checking testbench of the UTF-8 aware byte escaper: byte streams in, rendered text checked.
`timescale 1ns / 1ps

module tb_utf8_aware_byte_escaper_unit;
	import ube_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0a;
	localparam logic [7:0] CHR_CR    = 8'h0d;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_TILDE = 8'h7e;
	localparam logic [7:0] CONT_MAX  = 8'hbf;

	typedef struct {
		logic [7:0] ch;
		logic       run_last;
		logic       text_end;
	} rendered_char_t;

	// Tracks the pending UTF-8 sequence and queues the characters each byte should render.
	class render_board;
		logic [7:0]     held[3];
		int             held_cnt;
		int             seq_width;
		logic [7:0]     staged[$];
		rendered_char_t rendered_q[$];
		int             errors;

		function new();
			held_cnt = 0;
			seq_width = 0;
			errors = 0;
		endfunction

		function logic [7:0] hex_digit(input logic [3:0] n);
			if (n < 4'd10)
				return 8'h30 + 8'(n);
			return 8'h61 + 8'(n) - 8'd10;
		endfunction

		function void stage_escape(input logic [7:0] b);
			staged.push_back(CHR_BSLASH);
			staged.push_back(CHR_X);
			staged.push_back(hex_digit(b[7:4]));
			staged.push_back(hex_digit(b[3:0]));
		endfunction

		function int seq_len(input logic [7:0] b);
			if (b >= 8'hc2 && b <= 8'hdf) return 2;
			if (b >= LEAD_E0 && b <= 8'hef) return 3;
			if (b >= LEAD_F0 && b <= LEAD_F4) return 4;
			return 0;
		endfunction

		function void flush_held();
			for (int k = 0; k < held_cnt; k++)
				stage_escape(held[k]);
			held_cnt = 0;
			seq_width = 0;
		endfunction

		function void start_fresh(input logic [7:0] b);
			int w;
			if (b < CONT_TAG) begin
				if ((b >= CHR_SPACE && b <= CHR_TILDE) || b == CHR_LF || b == CHR_CR
						|| b == CHR_TAB)
					staged.push_back(b);
				else
					stage_escape(b);
				return;
			end
			w = seq_len(b);
			if (w == 0) begin
				stage_escape(b);
				return;
			end
			held[0] = b;
			held_cnt = 1;
			seq_width = w;
		endfunction

		// The second byte of E0, ED, F0 and F4 sequences has a narrower range.
		function bit extends_seq(input logic [7:0] b);
			if ((b & CONT_MASK) != CONT_TAG)
				return 0;
			if (held_cnt == 1) begin
				if (held[0] == LEAD_E0 && b < LIM_A0) return 0;
				if (held[0] == LEAD_ED && b >= LIM_A0) return 0;
				if (held[0] == LEAD_F0 && b < LIM_90) return 0;
				if (held[0] == LEAD_F4 && b >= LIM_90) return 0;
			end
			return 1;
		endfunction

		function void note_byte(input logic [7:0] b, input logic last);
			rendered_char_t r;
			staged.delete();
			if (held_cnt == 0) begin
				start_fresh(b);
			end else if (!extends_seq(b)) begin
				flush_held();
				start_fresh(b);
			end else if (held_cnt + 1 >= seq_width) begin
				for (int k = 0; k < held_cnt; k++)
					staged.push_back(held[k]);
				staged.push_back(b);
				held_cnt = 0;
				seq_width = 0;
			end else begin
				held[held_cnt] = b;
				held_cnt++;
			end
			if (last && held_cnt != 0)
				flush_held();
			foreach (staged[k]) begin
				r.ch = staged[k];
				r.run_last = (k == staged.size() - 1);
				r.text_end = r.run_last && last;
				rendered_q.push_back(r);
			end
		endfunction

		function void check_char(input logic [7:0] ch, input logic rl, input logic te);
			rendered_char_t r;
			if (rendered_q.size() == 0) begin
				$error("unexpected output character 0x%02h", ch);
				errors++;
				return;
			end
			r = rendered_q.pop_front();
			if (ch !== r.ch) begin
				$error("out_char mismatch: expected 0x%02h, got 0x%02h", r.ch, ch);
				errors++;
			end
			if (rl !== r.run_last) begin
				$error("run_last mismatch: expected %0b, got %0b", r.run_last, rl);
				errors++;
			end
			if (te !== r.text_end) begin
				$error("text_end mismatch: expected %0b, got %0b", r.text_end, te);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	render_board board;
	logic [7:0]  text_q[$];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          items_sent;
	int          cycle_count;

	utf8_aware_byte_escaper_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_utf8_aware_byte_escaper_unit failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the item was taken.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_byte(b, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic play_text();
		foreach (text_q[k])
			send_byte(text_q[k], k == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.rendered_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_lead(input int w);
		if (w == 2) return 8'($urandom_range(8'hdf, 8'hc2));
		if (w == 3) return 8'($urandom_range(8'hef, LEAD_E0));
		return 8'($urandom_range(LEAD_F4, LEAD_F0));
	endfunction

	function automatic logic [7:0] non_cont_byte();
		if ($urandom_range(1, 0))
			return 8'($urandom_range(8'h7f, 8'h00));
		return 8'($urandom_range(8'hff, 8'hc0));
	endfunction

	// A second byte inside or outside the range that the lead allows.
	function automatic logic [7:0] second_byte(input logic [7:0] lead, input bit good);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_TAG;
		hi = CONT_MAX;
		if (lead == LEAD_E0) lo = LIM_A0;
		if (lead == LEAD_ED) hi = LIM_A0 - 8'd1;
		if (lead == LEAD_F0) lo = LIM_90;
		if (lead == LEAD_F4) hi = LIM_90 - 8'd1;
		if (good)
			return 8'($urandom_range(hi, lo));
		if (lo != CONT_TAG && $urandom_range(1, 0))
			return 8'($urandom_range(lo - 8'd1, CONT_TAG));
		if (hi != CONT_MAX && $urandom_range(1, 0))
			return 8'($urandom_range(CONT_MAX, hi + 8'd1));
		return non_cont_byte();
	endfunction

	task automatic add_unit();
		int         kind;
		int         w;
		int         n_cont;
		int         fail_at;
		logic [7:0] lead;
		kind = $urandom_range(99, 0);
		w = $urandom_range(4, 2);
		lead = pick_lead(w);
		if (kind < 30) begin
			text_q.push_back(8'($urandom_range(CHR_TILDE, CHR_SPACE)));
		end else if (kind < 38) begin
			text_q.push_back(8'($urandom_range(8'h7f, 8'h00)));
		end else if (kind < 80) begin
			// Complete sequence, or one cut short before its last byte.
			n_cont = (kind < 70) ? w - 1 : $urandom_range(w - 2, 0);
			text_q.push_back(lead);
			if (n_cont > 0)
				text_q.push_back(second_byte(lead, 1));
			for (int k = 1; k < n_cont; k++)
				text_q.push_back(8'($urandom_range(CONT_MAX, CONT_TAG)));
		end else if (kind < 90) begin
			fail_at = $urandom_range(w - 1, 1);
			text_q.push_back(lead);
			if (fail_at == 1) begin
				text_q.push_back(second_byte(lead, 0));
			end else begin
				text_q.push_back(second_byte(lead, 1));
				for (int k = 2; k < fail_at; k++)
					text_q.push_back(8'($urandom_range(CONT_MAX, CONT_TAG)));
				text_q.push_back(non_cont_byte());
			end
		end else begin
			text_q.push_back(8'($urandom_range(8'hff, 8'h00)));
		end
	endtask

	initial begin
		int n_units;
		bit paused;
		board = new();
		paused = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		items_sent = 0;
		send_idle_pct = 37;
		recv_idle_pct = 63;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ASCII extremes, controls, invalid leads.
		text_q = {8'h00, 8'h0a, 8'h7e, 8'h7f, 8'hff, 8'hc1, 8'hf5};
		play_text();
		// A valid C2 80 sequence, then second-byte limits that break E0, ED, F0 and F4 sequences.
		text_q = {8'hc2, 8'h80, 8'he0, 8'h9f, 8'hed, 8'ha0, 8'hf0, 8'h8f, 8'hf4, 8'h90};
		play_text();
		// A valid three-byte sequence, then a four-byte one cut off by the end of text.
		text_q = {8'he0, 8'ha0, 8'h80, 8'hf1, 8'h80, 8'h80};
		play_text();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 37 : 0;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) begin
				n_units = $urandom_range(12, 1);
				for (int u = 0; u < n_units; u++)
					add_unit();
				play_text();
				// Halfway through the first phase the sender waits for the output to empty.
				if (phase == 0 && !paused && items_sent >= PHASE_ITEMS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.rendered_q.size() == 0)
			$display("tb_utf8_aware_byte_escaper_unit passed");
		else
			$display("tb_utf8_aware_byte_escaper_unit failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ube_pkg.sv
rtl/ube_front.sv
rtl/ube_emit.sv
rtl/utf8_aware_byte_escaper_unit.sv
tb/tb_utf8_aware_byte_escaper_unit.sv
